FILE: rtl/h264fua_pkg.sv
// ----------------------------------------------------------------------------
// h264fua_pkg
// Shared widths, register indexes, header constants and the queue entry type
// of the H.264 RTP FU-A packetizer.
// ----------------------------------------------------------------------------
package h264fua_pkg;

    // field widths
    localparam int BYTE_W     = 8;
    localparam int LEN_W      = 24;
    localparam int SEQ_W      = 16;
    localparam int TS_W       = 32;
    localparam int SSRC_W     = 32;
    localparam int MPS_W      = 16;
    localparam int S_DATA_W   = 64;
    localparam int M_DATA_W   = 88;
    localparam int M_USER_W   = 3;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam logic [CFG_IDX_W-1:0] REG_SSRC        = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INIT_SEQ    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_PAYLOAD = 2'd2;
    localparam logic [MPS_W-1:0]     MPS_RESET       = 16'd1400;

    // FU-A header constants
    localparam logic [BYTE_W-1:0] NRI_MASK  = 8'hE0;
    localparam logic [BYTE_W-1:0] FU_A_TYPE = 8'd28;
    localparam logic [BYTE_W-1:0] FU_START  = 8'h80;
    localparam logic [BYTE_W-1:0] FU_END    = 8'h40;
    localparam int                TYPE_W    = 5;

    // front-to-back queue
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    // tuser bit positions on the output side
    localparam int USER_START = 0;
    localparam int USER_MARK  = 1;
    localparam int USER_LAST  = 2;

    // One queue entry: all words caused by one input byte
    typedef struct packed {
        logic              three_word;   // indicator + FU header + data
        logic [BYTE_W-1:0] indicator;
        logic [BYTE_W-1:0] fu_header;
        logic [BYTE_W-1:0] data;
        logic              start;        // start flag of the data word
        logic              end_flag;     // end flag of the data word
        logic              marker;
        logic [SEQ_W-1:0]  seq;
        logic [TS_W-1:0]   ts;
    } fua_entry_t;

endpackage

FILE: rtl/h264fua_front.sv
// ----------------------------------------------------------------------------
// h264fua_front
// Accepts NAL bytes, tracks unit position, decides single/FU-A/drop per unit,
// assigns sequence numbers and pushes one entry per byte that gives output.
// ----------------------------------------------------------------------------
module h264fua_front
    import h264fua_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_DATA_W-1:0]   s_tdata,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  q_full,
    output logic                  q_push,
    output fua_entry_t            q_entry,
    output logic [SSRC_W-1:0]     ssrc
);

    typedef enum logic [1:0] {
        MODE_SINGLE = 2'd0,
        MODE_FRAG   = 2'd1,
        MODE_DROP   = 2'd2
    } mode_t;

    logic [SSRC_W-1:0] ssrc_reg;
    logic [MPS_W-1:0]  mps_reg;
    logic [SEQ_W-1:0]  next_seq_reg, next_seq_next;
    logic [SEQ_W-1:0]  open_seq_reg, open_seq_next;
    logic [LEN_W-1:0]  pos_reg, pos_next;
    logic [LEN_W-1:0]  ulen_reg, ulen_next;
    logic [TS_W-1:0]   ts_reg, ts_next;
    logic [MPS_W-1:0]  fill_reg, fill_next;
    mode_t             mode_reg, mode_next;
    logic [BYTE_W-1:0] ind_reg, ind_next;
    logic [TYPE_W-1:0] type_reg, type_next;

    logic [BYTE_W-1:0] in_byte;
    logic [LEN_W-1:0]  in_len;
    logic [TS_W-1:0]   in_ts;
    logic              accept;
    logic [LEN_W:0]    pos_inc;
    logic [MPS_W-1:0]  cap;
    logic [LEN_W-1:0]  frag_start;
    logic              frag_last;
    logic              frag_end;
    logic [LEN_W-1:0]  len_ref;

    assign in_byte  = s_tdata[BYTE_W-1:0];
    assign in_len   = s_tdata[BYTE_W+LEN_W-1:BYTE_W];
    assign in_ts    = s_tdata[BYTE_W+LEN_W+TS_W-1:BYTE_W+LEN_W];
    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;
    assign ssrc     = ssrc_reg;

    // fragment geometry
    assign pos_inc    = (LEN_W+1)'(pos_reg) + (LEN_W+1)'(1);
    assign cap        = (mps_reg > MPS_W'(3)) ? (mps_reg - MPS_W'(2)) : MPS_W'(1);
    assign frag_start = pos_reg - LEN_W'(fill_reg);
    assign frag_last  = ((LEN_W+1)'(frag_start) + (LEN_W+1)'(cap)) >= (LEN_W+1)'(ulen_reg);
    assign frag_end   = ((MPS_W+1)'(fill_reg) + (MPS_W+1)'(1) >= (MPS_W+1)'(cap))
                        || (pos_inc >= (LEN_W+1)'(ulen_reg));

    // per-byte unit tracking
    always_comb begin
        next_seq_next = next_seq_reg;
        open_seq_next = open_seq_reg;
        pos_next      = pos_reg;
        ulen_next     = ulen_reg;
        ts_next       = ts_reg;
        fill_next     = fill_reg;
        mode_next     = mode_reg;
        ind_next      = ind_reg;
        type_next     = type_reg;
        q_push        = 1'b0;
        q_entry       = '0;
        len_ref       = ulen_reg;

        q_entry.data  = in_byte;
        q_entry.ts    = ts_reg;
        q_entry.seq   = open_seq_reg;

        if (accept) begin
            if (pos_reg == '0) begin
                len_ref = in_len;
                if (in_len != '0) begin
                    ulen_next  = in_len;
                    ts_next    = in_ts;
                    q_entry.ts = in_ts;
                    fill_next  = '0;
                    if (mps_reg == '0) begin
                        mode_next = MODE_DROP;
                    end else if (in_len <= LEN_W'(mps_reg)) begin
                        mode_next = MODE_SINGLE;
                    end else if (mps_reg <= MPS_W'(2)) begin
                        mode_next = MODE_DROP;
                    end else begin
                        mode_next = MODE_FRAG;
                    end

                    if (mode_next == MODE_SINGLE) begin
                        q_push           = 1'b1;
                        q_entry.start    = 1'b1;
                        q_entry.end_flag = (in_len == LEN_W'(1));
                        q_entry.marker   = 1'b1;
                        q_entry.seq      = next_seq_reg;
                        open_seq_next    = next_seq_reg;
                        next_seq_next    = next_seq_reg + SEQ_W'(1);
                    end else if (mode_next == MODE_FRAG) begin
                        // header byte is consumed here
                        ind_next  = (in_byte & NRI_MASK) | FU_A_TYPE;
                        type_next = in_byte[TYPE_W-1:0];
                    end
                end
            end else if (mode_reg == MODE_SINGLE) begin
                q_push           = 1'b1;
                q_entry.end_flag = (pos_inc == (LEN_W+1)'(ulen_reg));
                q_entry.marker   = 1'b1;
            end else if (mode_reg == MODE_FRAG) begin
                q_push           = 1'b1;
                q_entry.end_flag = frag_end;
                q_entry.marker   = frag_last;
                q_entry.indicator = ind_reg;
                q_entry.fu_header = BYTE_W'(type_reg)
                                    | ((pos_reg == LEN_W'(1)) ? FU_START : '0)
                                    | (frag_last ? FU_END : '0);
                // a new fragment opens: take the next sequence number
                if (fill_reg == '0) begin
                    q_entry.three_word = 1'b1;
                    q_entry.seq        = next_seq_reg;
                    open_seq_next      = next_seq_reg;
                    next_seq_next      = next_seq_reg + SEQ_W'(1);
                end
                fill_next = frag_end ? '0 : (fill_reg + MPS_W'(1));
            end

            // advance position; zero-length first byte leaves it at zero
            if (pos_reg != '0 || in_len != '0) begin
                if (pos_inc >= (LEN_W+1)'(len_ref)) begin
                    pos_next  = '0;
                    fill_next = '0;
                end else begin
                    pos_next = pos_inc[LEN_W-1:0];
                end
            end
        end

        // sequence register write reloads the counter
        if (cfg_we && cfg_addr == REG_INIT_SEQ) begin
            next_seq_next = cfg_wdata[SEQ_W-1:0];
        end
    end

    // state and configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ssrc_reg     <= '0;
            mps_reg      <= MPS_RESET;
            next_seq_reg <= '0;
            open_seq_reg <= '0;
            pos_reg      <= '0;
            ulen_reg     <= '0;
            ts_reg       <= '0;
            fill_reg     <= '0;
            mode_reg     <= MODE_SINGLE;
            ind_reg      <= '0;
            type_reg     <= '0;
        end else begin
            next_seq_reg <= next_seq_next;
            open_seq_reg <= open_seq_next;
            pos_reg      <= pos_next;
            ulen_reg     <= ulen_next;
            ts_reg       <= ts_next;
            fill_reg     <= fill_next;
            mode_reg     <= mode_next;
            ind_reg      <= ind_next;
            type_reg     <= type_next;
            if (cfg_we && cfg_addr == REG_SSRC) begin
                ssrc_reg <= cfg_wdata[SSRC_W-1:0];
            end
            if (cfg_we && cfg_addr == REG_MAX_PAYLOAD) begin
                mps_reg <= cfg_wdata[MPS_W-1:0];
            end
        end
    end

endmodule

FILE: rtl/h264fua_fifo.sv
// ----------------------------------------------------------------------------
// h264fua_fifo
// Short queue of per-byte entries between the front and back parts.
// ----------------------------------------------------------------------------
module h264fua_fifo
    import h264fua_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       push,
    input  fua_entry_t push_entry,
    output logic       full,
    input  logic       pop,
    output logic       head_valid,
    output fua_entry_t head_entry
);

    fua_entry_t              mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0]   wr_ptr_reg;
    logic [FIFO_PTR_W-1:0]   rd_ptr_reg;
    logic [FIFO_CNT_W-1:0]   cnt_reg, cnt_next;
    logic                    do_push;
    logic                    do_pop;

    assign full       = (cnt_reg == FIFO_CNT_W'(FIFO_DEPTH));
    assign head_valid = (cnt_reg != '0);
    assign head_entry = mem[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    // occupancy
    always_comb begin
        cnt_next = cnt_reg;
        if (do_push && !do_pop) begin
            cnt_next = cnt_reg + FIFO_CNT_W'(1);
        end else if (do_pop && !do_push) begin
            cnt_next = cnt_reg - FIFO_CNT_W'(1);
        end
    end

    // pointers and count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            cnt_reg <= cnt_next;
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + FIFO_PTR_W'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + FIFO_PTR_W'(1);
            end
        end
    end

    // entry storage
    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

FILE: rtl/h264fua_back.sv
// ----------------------------------------------------------------------------
// h264fua_back
// Expands each queue entry into one or three output words and holds them in
// the output register until the receiver takes them.
// ----------------------------------------------------------------------------
module h264fua_back
    import h264fua_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                q_valid,
    input  fua_entry_t          q_entry,
    output logic                q_pop,
    input  logic [SSRC_W-1:0]   ssrc,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata,
    output logic                m_tlast,
    output logic [M_USER_W-1:0] m_tuser
);

    logic                valid_reg;
    logic [1:0]          sub_reg, sub_next;
    logic [BYTE_W-1:0]   byte_reg, byte_next;
    logic                start_reg, start_next;
    logic                end_reg, end_next;
    logic                mark_reg;
    logic                lastw_reg, lastw_next;
    logic [SEQ_W-1:0]    seq_reg;
    logic [TS_W-1:0]     ts_reg;
    logic [SSRC_W-1:0]   ssrc_reg;
    logic                load;

    assign load  = q_valid && (!valid_reg || m_tready);
    assign q_pop = load && lastw_next;

    // pick the word of the head entry
    always_comb begin
        byte_next  = q_entry.data;
        start_next = q_entry.start;
        end_next   = q_entry.end_flag;
        lastw_next = 1'b1;
        sub_next   = 2'd0;
        if (q_entry.three_word) begin
            if (sub_reg == 2'd0) begin
                byte_next  = q_entry.indicator;
                start_next = 1'b1;
                end_next   = 1'b0;
                lastw_next = 1'b0;
                sub_next   = 2'd1;
            end else if (sub_reg == 2'd1) begin
                byte_next  = q_entry.fu_header;
                start_next = 1'b0;
                end_next   = 1'b0;
                lastw_next = 1'b0;
                sub_next   = 2'd2;
            end
        end
    end

    // control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            sub_reg   <= 2'd0;
        end else begin
            if (load) begin
                valid_reg <= 1'b1;
                sub_reg   <= sub_next;
            end else if (m_tready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    // output word register
    always_ff @(posedge aclk) begin
        if (load) begin
            byte_reg  <= byte_next;
            start_reg <= start_next;
            end_reg   <= end_next;
            mark_reg  <= q_entry.marker;
            lastw_reg <= lastw_next;
            seq_reg   <= q_entry.seq;
            ts_reg    <= q_entry.ts;
            ssrc_reg  <= ssrc;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {ssrc_reg, ts_reg, seq_reg, byte_reg};
    assign m_tlast  = end_reg;
    assign m_tuser  = {lastw_reg, mark_reg, start_reg};

endmodule

FILE: rtl/h264_nal_rtp_fua_packetizer_unit.sv
// ----------------------------------------------------------------------------
// h264_nal_rtp_fua_packetizer_unit
// H.264 NAL unit to RTP payload packetizer, single packet or FU-A fragments.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream: one NAL byte per word; length and timestamp are taken from
//   the first word of each unit. Output stream: one payload byte per word
//   with its packet's sequence number, timestamp and SSRC; tlast marks the
//   last byte of a packet, tuser carries start, marker and end-of-input flags.
//   Configuration is written through cfg_we/cfg_addr/cfg_wdata while idle.
// Path: an accepted byte is written into the queue, then into the output
//   register, from which the receiver takes it.
// Throughput: one byte per cycle for single packets and fragment bodies
//   while the receiver is ready. The byte that opens an FU-A fragment
//   yields three words (indicator, FU header, data) sent in turn; the
//   four-entry queue absorbs this and the input stalls only when it fills.
// Reset: clears the queue and output register; SSRC and sequence reset to 0,
//   payload limit to 1400 bytes.
// Receiver stall: the output word holds; the queue keeps taking input bytes
//   until it is full, then s_tready drops.
// ----------------------------------------------------------------------------
module h264_nal_rtp_fua_packetizer_unit
    import h264fua_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // nal_byte[7:0], nal_length[31:8], media_timestamp[63:32]
    input  logic [S_DATA_W-1:0]   s_tdata,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // payload_byte[7:0], sequence_number[23:8], packet_timestamp[55:24],
    // packet_ssrc[87:56]
    output logic [M_DATA_W-1:0]   m_tdata,
    output logic                  m_tlast,
    // packet_start[0], marker_bit[1], last_of_item[2]
    output logic [M_USER_W-1:0]   m_tuser,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    fua_entry_t        push_entry;
    fua_entry_t        head_entry;
    logic              push;
    logic              full;
    logic              head_valid;
    logic              pop;
    logic [SSRC_W-1:0] ssrc;

    h264fua_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .q_full    (full),
        .q_push    (push),
        .q_entry   (push_entry),
        .ssrc      (ssrc)
    );

    h264fua_fifo u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .full       (full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_entry (head_entry)
    );

    h264fua_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (head_valid),
        .q_entry  (head_entry),
        .q_pop    (pop),
        .ssrc     (ssrc),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule

FILE: rtl/h264fua_checker.sv
// ----------------------------------------------------------------------------
// h264fua_checker
// Port-level checks on the packetizer output stream, bound to the top level.
// ----------------------------------------------------------------------------
module h264fua_checker
    import h264fua_pkg::*;
(
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [M_DATA_W-1:0]   m_tdata,
    input logic                  m_tlast,
    input logic [M_USER_W-1:0]   m_tuser
);

    // no output word right after reset
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

    // stalled word holds
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                  && $stable(m_tlast))
        else $error("output word changed under stall");

    // packet end only on the final word of an input byte
    a_end_on_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[USER_LAST] |-> !m_tlast)
        else $error("packet end on an inserted header word");

    // inserted packet opener is an FU indicator of type 28
    a_indicator_type: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[USER_LAST] && m_tuser[USER_START]
        |-> m_tdata[TYPE_W-1:0] == FU_A_TYPE[TYPE_W-1:0])
        else $error("fragment indicator type wrong");

    // header words are followed at once by a word of the same packet
    a_seq_follow: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && !m_tuser[USER_LAST]
        |=> m_tvalid && m_tdata[BYTE_W+SEQ_W-1:BYTE_W]
                        == $past(m_tdata[BYTE_W+SEQ_W-1:BYTE_W]))
        else $error("fragment words split or renumbered");

endmodule

bind h264_nal_rtp_fua_packetizer_unit h264fua_checker u_h264fua_checker (.*);
